// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the cache tag unit.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/core/sawc_pkg.sv -----
// Package of the cache tag unit: payload types, sizes and register codes.
// Depends on nothing.
package sawc_pkg;
	localparam int NUM_SETS_DEF = 8;
	localparam int NUM_WAYS_DEF = 4;
	localparam int BLOCK_BYTES_DEF = 32;
	localparam int ADDR_W = 32;
	localparam int CNT_W = 32;
	localparam int LAT_W = 9;
	localparam int DIRTY_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKUP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic req_type;
	} req_t;

	typedef struct packed {
		logic [LAT_W-1:0] latency;
		logic hit;
		logic wrote_back;
		logic [CNT_W-1:0] load_count;
		logic [CNT_W-1:0] store_count;
		logic [CNT_W-1:0] load_miss_count;
		logic [CNT_W-1:0] store_miss_count;
		logic [CNT_W-1:0] writeback_count;
		logic [DIRTY_W-1:0] dirty_lines;
	} rsp_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction
endpackage

// ----- rtl/core/sawc_fifo.sv -----
// Small two-entry queue that carries transactions from the front to the back.
// Depends on sawc_pkg for the request type.
module sawc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sawc_pkg::req_t wdata,
	output logic full,
	input logic pop,
	output logic empty,
	output sawc_pkg::req_t rdata
);
	import sawc_pkg::*;

	req_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wptr_q <= ~wptr_q;
			end
			if (pop && !empty) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule

// ----- rtl/core/sawc_back.sv -----
// Back end of the cache tag unit: tag state, replacement, counters, result register.
// Depends on sawc_pkg.
module sawc_back #(
	parameter int NUM_SETS = sawc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = sawc_pkg::NUM_WAYS_DEF,
	parameter int BLOCK_BYTES = sawc_pkg::BLOCK_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input sawc_pkg::req_t in_req,
	output logic in_take,
	input logic cache_enable,
	input logic [sawc_pkg::CFG_DATA_W-1:0] hit_lat,
	input logic [sawc_pkg::CFG_DATA_W-1:0] fill_lat,
	input logic [sawc_pkg::CFG_DATA_W-1:0] evict_lat,
	output logic empty,
	input logic pop,
	output sawc_pkg::rsp_t rsp
);
	import sawc_pkg::*;

	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int TAG_W = ADDR_W - OFF_W - SET_W;

	logic [TAG_W-1:0] tag_q [NUM_SETS][NUM_WAYS];
	logic valid_q [NUM_SETS][NUM_WAYS];
	logic dirty_q [NUM_SETS][NUM_WAYS];
	logic [WAY_W-1:0] vptr_q [NUM_SETS];
	logic [CNT_W-1:0] loads_q, stores_q, lmiss_q, smiss_q, wb_q;
	logic [DIRTY_W-1:0] dirty_total_q;
	rsp_t out_q;
	logic out_valid_q;

	logic [SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic is_store, hit, was_dirty, do_it;
	logic [WAY_W-1:0] hit_way, vp;
	logic [LAT_W-1:0] lat;

	assign set_idx = in_req.address[OFF_W +: SET_W];
	assign tag = in_req.address[ADDR_W-1 -: TAG_W];
	assign is_store = in_req.req_type;
	assign in_take = in_valid && (!out_valid_q || pop);
	assign do_it = in_take && cache_enable;
	assign vp = vptr_q[set_idx];
	assign was_dirty = valid_q[set_idx][vp] && dirty_q[set_idx][vp];
	assign empty = !out_valid_q;
	assign rsp = out_q;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (valid_q[set_idx][w] && tag_q[set_idx][w] == tag) begin
				hit = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		if (!cache_enable) begin
			lat = {1'b0, is_store ? evict_lat : fill_lat};
		end else if (hit) begin
			lat = {1'b0, hit_lat};
		end else if (was_dirty) begin
			lat = {1'b0, evict_lat} + {1'b0, fill_lat};
		end else begin
			lat = {1'b0, fill_lat};
		end
	end

	always_ff @(posedge clk) begin
		if (do_it && !hit) begin
			tag_q[set_idx][vp] <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				vptr_q[s] <= '0;
				for (int w = 0; w < NUM_WAYS; w++) begin
					valid_q[s][w] <= 1'b0;
					dirty_q[s][w] <= 1'b0;
				end
			end
			loads_q <= '0;
			stores_q <= '0;
			lmiss_q <= '0;
			smiss_q <= '0;
			wb_q <= '0;
			dirty_total_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			logic [CNT_W-1:0] ld_n, st_n, lm_n, sm_n, wb_n;
			logic [DIRTY_W-1:0] dt_n;
			ld_n = loads_q;
			st_n = stores_q;
			lm_n = lmiss_q;
			sm_n = smiss_q;
			wb_n = wb_q;
			dt_n = dirty_total_q;
			if (do_it) begin
				if (is_store) begin
					st_n = sat_inc(stores_q);
				end else begin
					ld_n = sat_inc(loads_q);
				end
				if (hit) begin
					if (is_store && !dirty_q[set_idx][hit_way]) begin
						dirty_q[set_idx][hit_way] <= 1'b1;
						dt_n = dt_n + 1'b1;
					end
				end else begin
					if (is_store) begin
						sm_n = sat_inc(smiss_q);
					end else begin
						lm_n = sat_inc(lmiss_q);
					end
					if (was_dirty) begin
						wb_n = sat_inc(wb_q);
						dt_n = dt_n - 1'b1;
					end
					if (is_store) begin
						dt_n = dt_n + 1'b1;
					end
					valid_q[set_idx][vp] <= 1'b1;
					dirty_q[set_idx][vp] <= is_store;
					vptr_q[set_idx] <= (32'(vp) == NUM_WAYS - 1) ? '0 : vp + 1'b1;
				end
			end
			loads_q <= ld_n;
			stores_q <= st_n;
			lmiss_q <= lm_n;
			smiss_q <= sm_n;
			wb_q <= wb_n;
			dirty_total_q <= dt_n;
			if (in_take) begin
				out_valid_q <= 1'b1;
				out_q.latency <= lat;
				out_q.hit <= cache_enable && hit;
				out_q.wrote_back <= cache_enable && !hit && was_dirty;
				out_q.load_count <= ld_n;
				out_q.store_count <= st_n;
				out_q.load_miss_count <= lm_n;
				out_q.store_miss_count <= sm_n;
				out_q.writeback_count <= wb_n;
				out_q.dirty_lines <= dt_n;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/core/set_assoc_writeback_cache_tags_unit.sv -----
// Top level of the cache tag unit: config registers, front queue, back end.
// Depends on sawc_pkg, sawc_fifo, sawc_back and assert_macros.svh.
// This unit models the tags of a write-back, write-allocate set-associative data cache
// with round-robin replacement. Each pushed transaction (an address and a load/store flag)
// yields exactly one result transaction with the latency it costs, hit and writeback
// flags, saturating statistics and the current number of dirty lines. Transactions enter
// a two-entry queue and are carried out one per cycle by the back end, which reads and
// updates the flip-flop tag state in that same cycle and registers the result; the
// sustained rate is one transaction per cycle while results are popped, and a result is
// on the result ports in the cycle after acceptance, which needs a free result register.
// Configuration writes must only happen while the unit is idle.
`include "assert_macros.svh"
module set_assoc_writeback_cache_tags_unit #(
	parameter int NUM_SETS = sawc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = sawc_pkg::NUM_WAYS_DEF,
	parameter int BLOCK_BYTES = sawc_pkg::BLOCK_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sawc_pkg::req_t req,
	output logic full,
	output logic empty,
	input logic pop,
	output sawc_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [sawc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [sawc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sawc_pkg::*;

	logic enable_q;
	logic [CFG_DATA_W-1:0] lookup_q, read_q, write_q;
	logic q_empty, q_take;
	req_t q_req;

	// Configuration registers; every index is defined so no write is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			lookup_q <= 8'd0;
			read_q <= 8'd30;
			write_q <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_LOOKUP: lookup_q <= cfg_data;
				REG_READ: read_q <= cfg_data;
				REG_WRITE: write_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sawc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(req), .full(full),
		.pop(q_take), .empty(q_empty), .rdata(q_req)
	);

	sawc_back #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .BLOCK_BYTES(BLOCK_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!q_empty), .in_req(q_req), .in_take(q_take),
		.cache_enable(enable_q), .hit_lat(lookup_q),
		.fill_lat(read_q), .evict_lat(write_q),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	// A result that is not taken must stay put.
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(rsp))
	// Hit and writeback cannot both be reported.
	`ASSERT_IMPLIES(a_excl, clk, arst_n, !empty, !(rsp.hit && rsp.wrote_back))
	// The dirty count never exceeds the number of lines.
	`ASSERT_IMPLIES(a_dirty, clk, arst_n, !empty, 32'(rsp.dirty_lines) <= NUM_SETS * NUM_WAYS)
endmodule
